// ===== design/number_to_english_word_tokens_macros.svh =====
// Assertion helpers included by n2e_checker.sv.
`ifndef NUMBER_TO_ENGLISH_WORD_TOKENS_MACROS_SVH
`define NUMBER_TO_ENGLISH_WORD_TOKENS_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define N2E_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("n2e: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define N2E_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("n2e: next-cycle check failed");

`endif

// ===== design/n2e_pkg.sv =====
package n2e_pkg;

  localparam int VALUE_W   = 31;
  localparam int WORD_W    = 5;
  localparam int DIGIT_N   = 10;
  localparam int GROUP_N   = 4;
  localparam int GSLOT_N   = 5;
  localparam int SLOT_N    = GROUP_N * GSLOT_N;
  localparam int SLOT_W    = $clog2(SLOT_N);
  localparam int BIN_W     = 32;
  localparam int BCD_W     = 4 * DIGIT_N;
  localparam int CONV_W    = BCD_W + BIN_W;
  localparam int BITS_PER_CYC = 4;
  localparam int CONV_CYC  = BIN_W / BITS_PER_CYC;
  localparam int CNT_W     = $clog2(CONV_CYC);
  localparam int Q_DEPTH   = 2;
  localparam int Q_AW      = $clog2(Q_DEPTH);

  typedef logic [WORD_W-1:0] word_t;

  localparam word_t W_ZERO      = 5'd0;
  localparam word_t W_TEN       = 5'd10;
  localparam word_t W_TENS_BASE = 5'd18;
  localparam word_t W_HUNDRED   = 5'd28;
  localparam word_t W_SCALE_BASE = 5'd28;

  typedef struct packed {
    logic [SLOT_N-1:0]  mask;
    word_t [SLOT_N-1:0] words;
  } tok_set_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_PUSH
  } front_state_t;

endpackage

// ===== design/n2e_front.sv =====
module n2e_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [n2e_pkg::VALUE_W-1:0] in_value,
  output logic                     q_push,
  input  logic                     q_full,
  output n2e_pkg::tok_set_t        q_din
);
  import n2e_pkg::*;

  front_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [CONV_W-1:0]    conv_r, conv_nxt;
  logic                 load, step;

  // One double-dabble step: correct each decimal digit, then shift in a bit.
  function automatic logic [CONV_W-1:0] dd_step(input logic [CONV_W-1:0] x);
    logic [CONV_W-1:0] y;
    y = x;
    for (int d = 0; d < DIGIT_N; d++) begin
      if (y[BIN_W + 4*d +: 4] >= 4'd5)
        y[BIN_W + 4*d +: 4] = y[BIN_W + 4*d +: 4] + 4'd3;
    end
    return {y[CONV_W-2:0], 1'b0};
  endfunction

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: if (in_valid) state_nxt = F_CONV;
      F_CONV: if (cnt_r == CNT_W'(CONV_CYC - 1)) state_nxt = F_PUSH;
      F_PUSH: begin
        if (!q_full) state_nxt = in_valid ? F_CONV : F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    q_push   = 1'b0;
    step     = 1'b0;
    case (state_r)
      F_IDLE: in_ready = 1'b1;
      F_CONV: step = 1'b1;
      F_PUSH: begin
        q_push   = !q_full;
        in_ready = !q_full;
      end
      default: ;
    endcase
  end

  assign load = in_valid && in_ready;

  always_comb begin
    conv_nxt = conv_r;
    cnt_nxt  = cnt_r;
    if (load) begin
      conv_nxt = CONV_W'(in_value);
      cnt_nxt  = '0;
    end else if (step) begin
      for (int b = 0; b < BITS_PER_CYC; b++)
        conv_nxt = dd_step(conv_nxt);
      cnt_nxt  = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    conv_r <= conv_nxt;
  end

  // Classify the decimal digits into token slots, highest group first.
  always_comb begin
    logic [3:0] dig [3*GROUP_N];
    logic [3:0] h, t, o;
    int         base;
    for (int d = 0; d < 3*GROUP_N; d++)
      dig[d] = (d < DIGIT_N) ? conv_r[BIN_W + 4*d +: 4] : 4'd0;
    q_din = '0;
    for (int g = 0; g < GROUP_N; g++) begin
      h    = dig[3*g+2];
      t    = dig[3*g+1];
      o    = dig[3*g];
      base = (GROUP_N - 1 - g) * GSLOT_N;
      q_din.mask[base]    = (h != 4'd0);
      q_din.words[base]   = {1'b0, h};
      q_din.mask[base+1]  = (h != 4'd0);
      q_din.words[base+1] = W_HUNDRED;
      q_din.mask[base+2]  = (t != 4'd0);
      q_din.words[base+2] = (t == 4'd1) ? W_TEN + {1'b0, o} : W_TENS_BASE + {1'b0, t};
      q_din.mask[base+3]  = (t != 4'd1) && (o != 4'd0);
      q_din.words[base+3] = {1'b0, o};
      q_din.mask[base+4]  = (g > 0) && ({h, t, o} != 12'd0);
      q_din.words[base+4] = W_SCALE_BASE + WORD_W'(g);
    end
    // Zero names itself.
    if (q_din.mask == '0) begin
      q_din.mask[0]  = 1'b1;
      q_din.words[0] = W_ZERO;
    end
  end

endmodule

// ===== design/n2e_queue.sv =====
module n2e_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  n2e_pkg::tok_set_t din,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output n2e_pkg::tok_set_t dout
);
  import n2e_pkg::*;

  tok_set_t          mem_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [Q_AW:0]     cnt_r, cnt_nxt;

  assign full  = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign valid = (cnt_r != '0);
  assign dout  = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) wr_nxt = (wr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_r + 1'b1;
    if (pop)  rd_nxt = (rd_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_r + 1'b1;
    if (push && !pop)      cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) mem_r[wr_r] <= din;
  end

endmodule

// ===== design/n2e_back.sv =====
module n2e_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  n2e_pkg::tok_set_t          q_dout,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [n2e_pkg::WORD_W-1:0] out_word,
  output logic                       out_last
);
  import n2e_pkg::*;

  logic [SLOT_N-1:0]  mask_r, mask_nxt;
  word_t [SLOT_N-1:0] words_r;
  logic               out_valid_r;
  word_t              out_word_r;
  logic               out_last_r;
  logic [SLOT_W-1:0]  sel_idx;
  logic               found, adv, is_last;
  logic [SLOT_N-1:0]  rest_mask;

  // Lowest set slot goes out next.
  always_comb begin
    sel_idx = '0;
    found   = 1'b0;
    for (int i = 0; i < SLOT_N; i++) begin
      if (!found && mask_r[i]) begin
        sel_idx = SLOT_W'(i);
        found   = 1'b1;
      end
    end
  end

  assign rest_mask = mask_r & (mask_r - 1'b1);
  assign is_last   = (rest_mask == '0);
  assign adv       = (mask_r != '0) && (!out_valid_r || out_ready);
  // Load the next value as the last token of this one leaves.
  assign q_pop     = q_valid && ((mask_r == '0) || (adv && is_last));

  always_comb begin
    mask_nxt = mask_r;
    if (q_pop)    mask_nxt = q_dout.mask;
    else if (adv) mask_nxt = rest_mask;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r <= mask_nxt;
      if (adv)            out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
    if (q_pop) words_r <= q_dout.words;
    if (adv) begin
      out_word_r <= words_r[sel_idx];
      out_last_r <= is_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_last  = out_last_r;

endmodule

// ===== design/number_to_english_word_tokens.sv =====
// Names a 31-bit unsigned value as a stream of English word codes, highest
// digit group first, with out_last on the final code; zero gives one code.
// The front end runs the binary-to-decimal converter at four bits a cycle,
// then hands the value to the two-entry queue; the back end sends one code
// per cycle while out_ready is high, 1 to 16 codes a value, moving straight
// on to the next queued value.
module number_to_english_word_tokens (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [n2e_pkg::VALUE_W-1:0] in_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [n2e_pkg::WORD_W-1:0]  out_word,
  output logic                        out_last
);
  import n2e_pkg::*;

  tok_set_t q_din, q_dout;
  logic     q_push, q_full, q_pop, q_valid;

  n2e_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_value (in_value),
    .q_push   (q_push),
    .q_full   (q_full),
    .q_din    (q_din)
  );

  n2e_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_dout)
  );

  n2e_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_dout    (q_dout),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .out_last  (out_last)
  );

endmodule

// ===== design/n2e_checker.sv =====
`include "number_to_english_word_tokens_macros.svh"

module n2e_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [n2e_pkg::WORD_W-1:0] out_word,
  input logic                       out_last
);
  import n2e_pkg::*;

  // Hold a stalled transaction.
  `N2E_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word) && $stable(out_last))
  // Zero only ever stands alone.
  `N2E_ASSERT_NOW(a_zero_alone, out_valid && (out_word == W_ZERO), out_last)
  // Nothing is offered in the cycle after reset.
  `N2E_ASSERT_NOW(a_idle_after_reset, !$past(rst_n), !out_valid)

endmodule

bind number_to_english_word_tokens n2e_checker u_n2e_checker (.*);
